// ===== rtl/core/xcfp_pkg.sv =====
package xcfp_pkg;

    // Frame status codes reported on the last beat of a buffer
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // One result beat as it travels from the parser to the output buffer
    typedef struct packed {
        logic       has_payload_byte;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic [1:0] frame_status;
        logic [7:0] frame_type;
    } xcfp_result_t;

endpackage

// ===== rtl/core/xor_checksum_frame_parser_unit.sv =====
// Channel | Direction | Handshake           | Beat fields
// input   | in        | in_valid / in_stall | rx_byte, end_of_buffer
// output  | out       | out_valid/out_stall | has_payload_byte, payload_byte, frame_end,
//         |           |                     | frame_status, frame_type
//
// One byte is taken every cycle while in_stall is low; its result beat, if any, is registered in the output buffer.
// The parser state loop (phase, running XOR, count) is combinational and registered on each taken byte.
// Bytes that are neither payload nor end of buffer give no output beat.
// rst_n clears the parser state and empties the output buffer at once.
// A two-entry output buffer parts the channels; in_stall rises only when both
// entries are held, so it comes straight from a register.
module xor_checksum_frame_parser_unit
    import xcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_buffer,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       has_payload_byte,
    output logic [7:0] payload_byte,
    output logic       frame_end,
    output logic [1:0] frame_status,
    output logic [7:0] frame_type
);

    logic         accept;
    logic         res_valid;
    logic         buf_full;
    xcfp_result_t result;
    xcfp_result_t out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    xcfp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .end_of_buffer (end_of_buffer),
        .res_valid     (res_valid),
        .result        (result)
    );

    xcfp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign has_payload_byte = out_data.has_payload_byte;
    assign payload_byte     = out_data.payload_byte;
    assign frame_end        = out_data.frame_end;
    assign frame_status     = out_data.frame_status;
    assign frame_type       = out_data.frame_type;

endmodule

// ===== rtl/core/xcfp_parser.sv =====
module xcfp_parser
    import xcfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   rx_byte,
    input  logic         end_of_buffer,
    output logic         res_valid,
    output xcfp_result_t result
);

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CHECK   = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;
    logic       match_reg, match_next;
    logic       pass;

    // Per-byte state update
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        match_next  = match_reg;
        pass        = 1'b0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                type_next  = rx_byte;
                xor_next   = rx_byte;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                length_next = rx_byte;
                xor_next    = xor_reg ^ rx_byte;
                count_next  = 8'd0;
                phase_next  = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                pass       = 1'b1;
                xor_next   = xor_reg ^ rx_byte;
                count_next = count_reg + 8'd1;
                if (count_next == length_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                match_next = (rx_byte == xor_reg);
                phase_next = PH_DONE;
            end
            default:
            begin
                // done, or a stray code: byte ignored
            end
        endcase
    end

    // Result beat for this byte
    always_comb
    begin
        res_valid               = pass || end_of_buffer;
        result.has_payload_byte = pass;
        result.payload_byte     = pass ? rx_byte : 8'd0;
        result.frame_end        = end_of_buffer;
        result.frame_status     = ST_OK;
        result.frame_type       = 8'd0;
        if (end_of_buffer)
        begin
            if (phase_next != PH_DONE)
            begin
                result.frame_status = ST_SHORT;
            end
            else
            begin
                result.frame_status = match_next ? ST_OK : ST_MISMATCH;
            end
            result.frame_type = type_next;
        end
    end

    // Parser state; the end of a buffer returns it to the start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            xor_reg    <= 8'd0;
            match_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_buffer)
            begin
                phase_reg  <= PH_TYPE;
                type_reg   <= 8'd0;
                length_reg <= 8'd0;
                count_reg  <= 8'd0;
                xor_reg    <= 8'd0;
                match_reg  <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                type_reg   <= type_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                xor_reg    <= xor_next;
                match_reg  <= match_next;
            end
        end
    end

endmodule

// ===== rtl/core/xcfp_out_skid.sv =====
module xcfp_out_skid
    import xcfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  xcfp_result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output xcfp_result_t out_data
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    xcfp_result_t main_reg;
    xcfp_result_t skid_reg;
    logic         pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Occupancy; a push only arrives while the skid entry is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Beat data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

// ===== rtl/core/xcfp_checker.sv =====
module xcfp_checker
    import xcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       has_payload_byte,
    input  logic [7:0] payload_byte,
    input  logic       frame_end,
    input  logic [1:0] frame_status,
    input  logic [7:0] frame_type
);

    // A held output beat keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(frame_end) && $stable(frame_status) && $stable(frame_type)
            && $stable(has_payload_byte))
        else $error("output beat changed while stalled");

    // Every beat carries a payload byte or ends a buffer
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> has_payload_byte || frame_end)
        else $error("empty output beat");

    // Status and type are zero away from the end of a buffer
    a_mid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> frame_status == ST_OK && frame_type == 8'd0)
        else $error("status or type set on a mid-buffer beat");

    // Status code range and zeroed payload lane
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_status == ST_OK || frame_status == ST_SHORT
            || frame_status == ST_MISMATCH) && (has_payload_byte || payload_byte == 8'd0))
        else $error("bad status code or stray payload byte");

    // Input stalls only while the output side holds a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with output empty");

endmodule

bind xor_checksum_frame_parser_unit xcfp_checker u_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import xcfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 400;

    // Parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CHECK   = 3'd3,
        PH_DONE    = 3'd4
    } parse_ph_t;

    // One row of the directed table
    typedef struct {
        bit [7:0]     rx;
        bit           last;
        bit           typed;
        xcfp_result_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       end_of_buffer;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       has_payload_byte;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [1:0] frame_status;
    logic [7:0] frame_type;

    xcfp_result_t frame_beats_q [$];
    stim_row_t    dir_rows [$];
    int           err_count = 0;
    int           items_sent = 0;
    int           cyc = 0;
    int           snd_idle = 0;
    int           rcv_stall = 0;

    // Predictor state
    parse_ph_t ph;
    bit [7:0]  h_type;
    bit [7:0]  h_len;
    bit [7:0]  p_cnt;
    bit [7:0]  run_x;
    bit        chk_ok;

    xor_checksum_frame_parser_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .end_of_buffer    (end_of_buffer),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .has_payload_byte (has_payload_byte),
        .payload_byte     (payload_byte),
        .frame_end        (frame_end),
        .frame_status     (frame_status),
        .frame_type       (frame_type)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cyc = cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic xcfp_result_t mk_res(input bit h, input bit [7:0] p, input bit e,
                                            input logic [1:0] s, input bit [7:0] t);
        xcfp_result_t r;
        r.has_payload_byte = h;
        r.payload_byte     = p;
        r.frame_end        = e;
        r.frame_status     = s;
        r.frame_type       = t;
        return r;
    endfunction

    task automatic frame_clear();
        ph     = PH_TYPE;
        h_type = '0;
        h_len  = '0;
        p_cnt  = '0;
        run_x  = '0;
        chk_ok = 1'b0;
    endtask

    // Steps the deframer by one byte; got says whether a beat comes out
    task automatic frame_predict(input bit [7:0] b, input bit last,
                                 output bit got, output xcfp_result_t r);
        bit         pass;
        logic [1:0] st;
        bit [7:0]   typ;
        pass = 1'b0;
        st   = ST_OK;
        typ  = '0;
        case (ph)
            PH_TYPE:
            begin
                h_type = b;
                run_x  = b;
                ph     = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                h_len = b;
                run_x = run_x ^ b;
                p_cnt = '0;
                ph    = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                pass  = 1'b1;
                run_x = run_x ^ b;
                p_cnt = p_cnt + 8'd1;
                if (p_cnt == h_len)
                    ph = PH_CHECK;
            end
            PH_CHECK:
            begin
                chk_ok = (b == run_x);
                ph     = PH_DONE;
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            if (ph != PH_DONE)
                st = ST_SHORT;
            else
                st = chk_ok ? ST_OK : ST_MISMATCH;
            typ = h_type;
        end
        got = pass || last;
        r   = mk_res(pass, pass ? b : 8'd0, last, st, typ);
        if (last)
            frame_clear();
    endtask

    // Offer one byte, idling first at random, and hold it until taken
    task automatic drive_byte(input bit [7:0] b, input bit last, input bit typed,
                              input xcfp_result_t want);
        bit           got;
        xcfp_result_t r;
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        rx_byte       <= b;
        end_of_buffer <= last;
        do
            @(posedge clk);
        while (in_stall);
        frame_predict(b, last, got, r);
        if (typed)
            frame_beats_q.push_back(want);
        else if (got)
            frame_beats_q.push_back(r);
        items_sent++;
    endtask

    // Sender holds off until every expected beat is back
    task automatic drain_beats();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_beats_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input bit [7:0] b, input bit last, input bit typed,
                           input xcfp_result_t want);
        stim_row_t row;
        row.rx    = b;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Random buffer: mostly well-formed frames, some corrupt, truncated or noise
    task automatic send_buffer();
        bit [7:0] bq [$];
        bit [7:0] x;
        int       kind;
        int       len;
        int       cut;
        int       n;
        kind = $urandom_range(0, 99);
        if (kind >= 88)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                bq.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
            x = 8'($urandom_range(0, 255));
            bq.push_back(x);
            bq.push_back(len[7:0]);
            x = x ^ len[7:0];
            repeat (len)
            begin
                bq.push_back(8'($urandom_range(0, 255)));
                x = x ^ bq[bq.size() - 1];
            end
            if (kind >= 60 && kind < 75)
                x = x ^ 8'($urandom_range(1, 255));
            bq.push_back(x);
            if (kind < 75 && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    bq.push_back(8'($urandom_range(0, 255)));
            end
            if (kind >= 75)
            begin
                cut = $urandom_range(1, bq.size() - 1);
                while (bq.size() > cut)
                    void'(bq.pop_back());
            end
        end
        foreach (bq[i])
            drive_byte(bq[i], i == bq.size() - 1, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Output side: check each taken beat, then stall at random
    always @(posedge clk)
    begin : out_mon
        xcfp_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (frame_beats_q.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected beat, expected none, actual %0h/%0h/%0h/%0h/%0h",
                         $time, has_payload_byte, payload_byte, frame_end,
                         frame_status, frame_type);
            end
            else
            begin
                want = frame_beats_q.pop_front();
                check_field("has_payload_byte", 8'(want.has_payload_byte), 8'(has_payload_byte));
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("frame_end", 8'(want.frame_end), 8'(frame_end));
                check_field("frame_status", 8'(want.frame_status), 8'(frame_status));
                check_field("frame_type", want.frame_type, frame_type);
            end
        end
        out_stall <= ($urandom_range(0, 99) < rcv_stall);
    end

    // Stimulus
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        end_of_buffer = 1'b0;
        frame_clear();

        // single byte buffer: too short
        add_row(8'hFF, 1'b1, 1'b1, mk_res(1'b0, 8'h00, 1'b1, ST_SHORT, 8'hFF));
        // two byte buffer: too short
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h05, 1'b1, 1'b1, mk_res(1'b0, 8'h00, 1'b1, ST_SHORT, 8'h00));
        // zero length, good check
        add_row(8'hA5, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hA5, 1'b1, 1'b1, mk_res(1'b0, 8'h00, 1'b1, ST_OK, 8'hA5));
        // zero length, bad check
        add_row(8'h3C, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, mk_res(1'b0, 8'h00, 1'b1, ST_MISMATCH, 8'h3C));
        // two payload bytes, good check, trailing bytes ignored
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFC, 1'b0, 1'b0, '0);
        add_row(8'h77, 1'b0, 1'b0, '0);
        add_row(8'h88, 1'b1, 1'b1, mk_res(1'b0, 8'h00, 1'b1, ST_OK, 8'h01));
        // buffer ends on a payload byte
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(8'h11, 1'b0, 1'b0, '0);
        add_row(8'h22, 1'b1, 1'b1, mk_res(1'b1, 8'h22, 1'b1, ST_SHORT, 8'h80));
        // maximum length, ends after the length byte
        add_row(8'h7F, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, mk_res(1'b0, 8'h00, 1'b1, ST_SHORT, 8'h7F));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, sender idles a little, receiver mostly stalled
        snd_idle  = 15;
        rcv_stall = 84;
        foreach (dir_rows[i])
            drive_byte(dir_rows[i].rx, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        // receiver mostly stalled
        while (items_sent < PHASE_ITEMS)
            send_buffer();
        drain_beats();

        // sender mostly idle
        snd_idle  = 84;
        rcv_stall = 15;
        while (items_sent < 2 * PHASE_ITEMS)
            send_buffer();
        drain_beats();

        // full rate both sides
        snd_idle  = 0;
        rcv_stall = 0;
        while (items_sent < 3 * PHASE_ITEMS)
            send_buffer();

        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_beats_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
